// ----- hdl/transformed_bounding_box_macros.svh -----
// assertion macros shared by the bounding box modules
// expects clk and arst_n in the scope of use
`ifndef TRANSFORMED_BOUNDING_BOX_MACROS_SVH
`define TRANSFORMED_BOUNDING_BOX_MACROS_SVH

// same-cycle implication
`define TBB_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define TBB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- hdl/tbb_pkg.sv -----
// types and constants of the transformed bounding box
// no dependencies
`default_nettype none

package tbb_pkg;

	localparam int COORD_W  = 32;
	localparam int REG_W    = 64;
	localparam int NUM_REGS = 6;
	localparam int REG_IDX_W = 3;
	localparam int FRAC_BITS = 16;

	localparam logic [REG_IDX_W-1:0] REG_ROW0_LO = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ROW0_HI = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ROW1_LO = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ROW1_HI = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ROW2_LO = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_ROW2_HI = 3'd5;

	localparam logic [REG_W-1:0] ROW0_LO_RST = 64'h0000_0000_0001_0000;
	localparam logic [REG_W-1:0] ROW0_HI_RST = 64'h0;
	localparam logic [REG_W-1:0] ROW1_LO_RST = 64'h0001_0000_0000_0000;
	localparam logic [REG_W-1:0] ROW1_HI_RST = 64'h0;
	localparam logic [REG_W-1:0] ROW2_LO_RST = 64'h0;
	localparam logic [REG_W-1:0] ROW2_HI_RST = 64'h0000_0000_0001_0000;

	// one transformed vertex in the queue
	typedef struct packed {
		logic [2:0][COORD_W-1:0] coord;
		logic                    last;
	} vtx_t;

endpackage

`default_nettype wire

// ----- hdl/transformed_bounding_box.sv -----
// Axis-aligned bounding box of affine-transformed vertices. Takes one vertex per
// cycle when the queue has room; the front end is a four-stage pipeline (intake,
// nine parallel 32x32 multipliers, partial sums, final sum with clamp) feeding a
// FIFO_DEPTH-entry queue, and the back end folds one vertex per cycle into the
// running extremes, holding a closing vertex while the output slot is full. The
// box of a set is offered from an output register, so vertices of the next set
// keep flowing while it waits. Configuration writes are never stalled.
// depends on tbb_pkg, tbb_front, tbb_fifo and tbb_back
`default_nettype none

module transformed_bounding_box #(
	parameter int FIFO_DEPTH = 4
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [tbb_pkg::REG_IDX_W-1:0] cfg_index,
	input  wire logic [tbb_pkg::REG_W-1:0]     cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [tbb_pkg::COORD_W-1:0]   pos_x,
	input  wire logic [tbb_pkg::COORD_W-1:0]   pos_y,
	input  wire logic [tbb_pkg::COORD_W-1:0]   pos_z,
	input  wire logic                           last_point,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [tbb_pkg::COORD_W-1:0]        min_x,
	output logic [tbb_pkg::COORD_W-1:0]        min_y,
	output logic [tbb_pkg::COORD_W-1:0]        min_z,
	output logic [tbb_pkg::COORD_W-1:0]        max_x,
	output logic [tbb_pkg::COORD_W-1:0]        max_y,
	output logic [tbb_pkg::COORD_W-1:0]        max_z
);
	import tbb_pkg::*;

	logic                    push_valid, push_ready;
	vtx_t                    push_data;
	logic                    pop_valid, pop_ready;
	vtx_t                    pop_data;
	logic [2:0][COORD_W-1:0] box_lo, box_hi;

	tbb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.last_point (last_point),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	tbb_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	tbb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.box_lo    (box_lo),
		.box_hi    (box_hi)
	);

	assign min_x = box_lo[0];
	assign min_y = box_lo[1];
	assign min_z = box_lo[2];
	assign max_x = box_hi[0];
	assign max_y = box_hi[1];
	assign max_z = box_hi[2];

endmodule

`default_nettype wire

// ----- hdl/tbb_front.sv -----
// front end: configuration registers, vertex intake and the affine transform pipeline
// depends on tbb_pkg
`default_nettype none

module tbb_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [tbb_pkg::REG_IDX_W-1:0] cfg_index,
	input  wire logic [tbb_pkg::REG_W-1:0]     cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [tbb_pkg::COORD_W-1:0]   pos_x,
	input  wire logic [tbb_pkg::COORD_W-1:0]   pos_y,
	input  wire logic [tbb_pkg::COORD_W-1:0]   pos_z,
	input  wire logic                           last_point,
	output logic                                push_valid,
	input  wire logic                           push_ready,
	output tbb_pkg::vtx_t                       push_data
);
	import tbb_pkg::*;

	localparam int PROD_W = 2 * COORD_W;
	localparam int PART_W = PROD_W + 1;
	localparam int SUM_W  = PROD_W + 2;
	localparam int SHR_W  = SUM_W - FRAC_BITS;

	logic [REG_W-1:0] row_q [NUM_REGS];

	logic                           adv;
	logic                           v_s1, v_s2, v_s3, v_s4;
	logic                           last_s1, last_s2, last_s3, last_s4;
	logic signed [COORD_W-1:0]      pos_s1 [3];
	logic signed [PROD_W-1:0]       prod_s2 [3][3];
	logic signed [COORD_W-1:0]      trans_s2 [3];
	logic signed [PART_W-1:0]       part_a_s3 [3];
	logic signed [PART_W-1:0]       part_b_s3 [3];
	logic [2:0][COORD_W-1:0]        coord_s4;
	logic [2:0][COORD_W-1:0]        coord_nxt;

	function automatic logic [COORD_W-1:0] saturate(input logic signed [SHR_W-1:0] v);
		logic [SHR_W-COORD_W:0] top;
		top = v[SHR_W-1:COORD_W-1];
		if (top == '0 || top == '1)
			return v[COORD_W-1:0];
		else if (v[SHR_W-1])
			return {1'b1, {(COORD_W-1){1'b0}}};
		else
			return {1'b0, {(COORD_W-1){1'b1}}};
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= ROW0_LO_RST;
			row_q[1] <= ROW0_HI_RST;
			row_q[2] <= ROW1_LO_RST;
			row_q[3] <= ROW1_HI_RST;
			row_q[4] <= ROW2_LO_RST;
			row_q[5] <= ROW2_HI_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ROW0_LO: row_q[0] <= cfg_data;
				REG_ROW0_HI: row_q[1] <= cfg_data;
				REG_ROW1_LO: row_q[2] <= cfg_data;
				REG_ROW1_HI: row_q[3] <= cfg_data;
				REG_ROW2_LO: row_q[4] <= cfg_data;
				REG_ROW2_HI: row_q[5] <= cfg_data;
				default: ;
			endcase
		end
	end

	// whole pipeline moves together
	assign adv      = !v_s4 || push_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s1[0] <= pos_x;
			pos_s1[1] <= pos_y;
			pos_s1[2] <= pos_z;
			last_s1   <= last_point;
			last_s2   <= last_s1;
			last_s3   <= last_s2;
			last_s4   <= last_s3;
			coord_s4  <= coord_nxt;
		end
	end

	for (genvar r = 0; r < 3; r++) begin : g_row
		logic signed [COORD_W-1:0] c0, c1, c2, tr;
		logic signed [SUM_W-1:0]   sum;

		assign c0 = row_q[2*r][COORD_W-1:0];
		assign c1 = row_q[2*r][REG_W-1:COORD_W];
		assign c2 = row_q[2*r+1][COORD_W-1:0];
		assign tr = row_q[2*r+1][REG_W-1:COORD_W];

		always_ff @(posedge clk) begin
			if (adv) begin
				prod_s2[r][0] <= PROD_W'(c0) * PROD_W'(pos_s1[0]);
				prod_s2[r][1] <= PROD_W'(c1) * PROD_W'(pos_s1[1]);
				prod_s2[r][2] <= PROD_W'(c2) * PROD_W'(pos_s1[2]);
				trans_s2[r]   <= tr;
				part_a_s3[r]  <= PART_W'(prod_s2[r][0]) + PART_W'(prod_s2[r][1]);
				part_b_s3[r]  <= PART_W'(prod_s2[r][2])
					+ (PART_W'(trans_s2[r]) <<< FRAC_BITS);
			end
		end

		// floor of the exact sum over 2^16, then clamp
		assign sum          = SUM_W'(part_a_s3[r]) + SUM_W'(part_b_s3[r]);
		assign coord_nxt[r] = saturate(sum[SUM_W-1:FRAC_BITS]);
	end

	assign push_valid      = v_s4;
	assign push_data.coord = coord_s4;
	assign push_data.last  = last_s4;

endmodule

`default_nettype wire

// ----- hdl/tbb_fifo.sv -----
// short queue of transformed vertices between the front and back ends
// depends on tbb_pkg and the assertion macros
`default_nettype none

module tbb_fifo #(
	parameter int DEPTH = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push_valid,
	output logic               push_ready,
	input  wire tbb_pkg::vtx_t push_data,
	output logic               pop_valid,
	input  wire logic          pop_ready,
	output tbb_pkg::vtx_t      pop_data
);
	import tbb_pkg::*;

	`include "transformed_bounding_box_macros.svh"

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	vtx_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push, pop;

	assign push_ready = count_q != FULL_CNT;
	assign pop_valid  = count_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	`TBB_ASSERT_NOW(a_count_bound, 1'b1, count_q <= FULL_CNT)
	`TBB_ASSERT_NEXT(a_push_grows, push && !pop, count_q == $past(count_q) + 1'b1)

endmodule

`default_nettype wire

// ----- hdl/tbb_back.sv -----
// back end: running per-axis extremes and the registered box output
// depends on tbb_pkg and the assertion macros
`default_nettype none

module tbb_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         pop_valid,
	output logic                              pop_ready,
	input  wire tbb_pkg::vtx_t                pop_data,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [2:0][tbb_pkg::COORD_W-1:0] box_lo,
	output logic [2:0][tbb_pkg::COORD_W-1:0] box_hi
);
	import tbb_pkg::*;

	`include "transformed_bounding_box_macros.svh"

	logic signed [COORD_W-1:0] low_q [3];
	logic signed [COORD_W-1:0] high_q [3];
	logic signed [COORD_W-1:0] lo_nxt [3];
	logic signed [COORD_W-1:0] hi_nxt [3];
	logic                      seen_q;
	logic                      out_valid_q;
	logic                      pop;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			lo_nxt[a] = (!seen_q || $signed(pop_data.coord[a]) < low_q[a])
				? $signed(pop_data.coord[a]) : low_q[a];
			hi_nxt[a] = (!seen_q || $signed(pop_data.coord[a]) > high_q[a])
				? $signed(pop_data.coord[a]) : high_q[a];
		end
	end

	// a closing vertex waits until the output slot is free
	assign pop_ready = !pop_data.last || !out_valid_q || out_ready;
	assign pop       = pop_valid && pop_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && pop_data.last)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (pop)
				seen_q <= !pop_data.last;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			for (int a = 0; a < 3; a++) begin
				low_q[a]  <= lo_nxt[a];
				high_q[a] <= hi_nxt[a];
				if (pop_data.last) begin
					box_lo[a] <= lo_nxt[a];
					box_hi[a] <= hi_nxt[a];
				end
			end
		end
	end

	`TBB_ASSERT_NEXT(a_last_closes_set, pop && pop_data.last, !seen_q && out_valid_q)

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// testbench for transformed_bounding_box: a directed table, then random vertex sets under
// changing transforms, each box checked against a predictor of the transform and extremes
// depends on tbb_pkg and the transformed_bounding_box rtl
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tbb_pkg::*;

	typedef struct packed {
		logic [COORD_W-1:0] min_x, min_y, min_z, max_x, max_y, max_z;
	} box_t;

	typedef enum logic {ROW_POINT, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [REG_IDX_W-1:0]  index;
		logic [REG_W-1:0]      data;
		logic [COORD_W-1:0]    x, y, z;
		logic                  last;
		logic                  typed;
		box_t                  box;
	} row_t;

	typedef enum int {
		SET_RESET, SET_ALL_MAX, SET_ALL_MIN, SET_ZERO, SET_SMALL, SET_WIDE, SET_MIXED
	} setting_t;

	localparam logic [REG_IDX_W-1:0] REG_UNUSED_LO = REG_IDX_W'(NUM_REGS);
	localparam logic [REG_IDX_W-1:0] REG_UNUSED_HI = '1;
	localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
	localparam logic signed [65:0] SAT_LO = -66'sd2147483648;
	localparam int SETTLE_CYCLES = 32;
	localparam int NUM_ROWS = 20;
	localparam int NUM_PHASES = 10;
	localparam int PHASE_POINTS = 64;
	localparam setting_t PHASE_PLAN [NUM_PHASES] = '{SET_RESET, SET_ALL_MAX, SET_ALL_MIN,
		SET_ZERO, SET_SMALL, SET_WIDE, SET_MIXED, SET_SMALL, SET_MIXED, SET_SMALL};
	localparam logic [REG_W-1:0] RESET_VALUES [NUM_REGS] = '{ROW0_LO_RST, ROW0_HI_RST,
		ROW1_LO_RST, ROW1_HI_RST, ROW2_LO_RST, ROW2_HI_RST};

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [REG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [COORD_W-1:0]   pos_x, pos_y, pos_z;
	logic                 last_point;
	logic                 out_valid;
	logic                 out_ready;
	logic [COORD_W-1:0]   min_x, min_y, min_z, max_x, max_y, max_z;

	logic [REG_W-1:0]          coeff_regs [NUM_REGS];
	logic signed [COORD_W-1:0] run_lo [3];
	logic signed [COORD_W-1:0] run_hi [3];
	logic                      run_open;
	box_t                      boxes_due [$];
	int                        error_count;
	int                        send_calm;
	int                        take_calm;

	transformed_bounding_box i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1ms;
		$display("testbench NOT OK");
		$finish;
	end

	task automatic report(string msg);
		$display("[%0t] %s", $time, msg);
		error_count++;
	endtask

	// wait cycles before the next request, with runs of back-to-back requests
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 5) == 0) begin
			calm = $urandom_range(4, 24);
			return 0;
		end
		return $urandom_range(0, 17);
	endfunction

	function automatic logic [COORD_W-1:0] transform_axis(int axis,
			logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic [COORD_W-1:0] z);
		logic signed [COORD_W-1:0] c0, c1, c2, shift;
		logic signed [65:0]        sum;
		c0 = coeff_regs[2 * axis][31:0];
		c1 = coeff_regs[2 * axis][63:32];
		c2 = coeff_regs[2 * axis + 1][31:0];
		shift = coeff_regs[2 * axis + 1][63:32];
		sum = c0 * $signed(x) + c1 * $signed(y) + c2 * $signed(z);
		sum = (sum >>> FRAC_BITS) + shift;
		if (sum > SAT_HI)
			return SAT_HI[COORD_W-1:0];
		if (sum < SAT_LO)
			return SAT_LO[COORD_W-1:0];
		return sum[COORD_W-1:0];
	endfunction

	function automatic logic fold_vertex(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
			logic [COORD_W-1:0] z, logic last, output box_t box);
		logic signed [COORD_W-1:0] p;
		for (int a = 0; a < 3; a++) begin
			p = transform_axis(a, x, y, z);
			if (!run_open) begin
				run_lo[a] = p;
				run_hi[a] = p;
			end else begin
				if (p < run_lo[a])
					run_lo[a] = p;
				if (p > run_hi[a])
					run_hi[a] = p;
			end
		end
		run_open = 1'b1;
		box = box_t'{run_lo[0], run_lo[1], run_lo[2], run_hi[0], run_hi[1], run_hi[2]};
		if (!last)
			return 1'b0;
		run_lo = '{default: '0};
		run_hi = '{default: '0};
		run_open = 1'b0;
		return 1'b1;
	endfunction

	function automatic row_t point_row(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
			logic [COORD_W-1:0] z, logic last);
		row_t row;
		row = '0;
		row.kind = ROW_POINT;
		row.x = x;
		row.y = y;
		row.z = z;
		row.last = last;
		return row;
	endfunction

	function automatic row_t checked_row(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
			logic [COORD_W-1:0] z, box_t box);
		row_t row;
		row = point_row(x, y, z, 1'b1);
		row.typed = 1'b1;
		row.box = box;
		return row;
	endfunction

	function automatic row_t write_row(logic [REG_IDX_W-1:0] index, logic [REG_W-1:0] data);
		row_t row;
		row = '0;
		row.kind = ROW_WRITE;
		row.index = index;
		row.data = data;
		return row;
	endfunction

	function automatic logic [COORD_W-1:0] draw_half(setting_t s);
		setting_t pick;
		pick = s;
		if (s == SET_MIXED)
			pick = setting_t'($urandom_range(SET_ALL_MAX, SET_WIDE));
		case (pick)
			SET_ALL_MAX: return 32'h7FFF_FFFF;
			SET_ALL_MIN: return 32'h8000_0000;
			SET_ZERO:    return '0;
			SET_SMALL:   return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
			default:     return $urandom();
		endcase
	endfunction

	function automatic logic [COORD_W-1:0] draw_coord();
		case ($urandom_range(0, 9))
			0:          return 32'h7FFF_FFFF;
			1:          return 32'h8000_0000;
			2, 3, 4, 5: return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
			default:    return $urandom();
		endcase
	endfunction

	task automatic write_reg(logic [REG_IDX_W-1:0] index, logic [REG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (index < NUM_REGS)
			coeff_regs[index] = data;
	endtask

	task automatic push_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
			logic [COORD_W-1:0] z, logic last, logic typed, box_t typed_box);
		int   gap;
		box_t box;
		gap = draw_wait(send_calm);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pos_x <= x;
		pos_y <= y;
		pos_z <= z;
		last_point <= last;
		do @(posedge clk); while (!in_ready);
		if (fold_vertex(x, y, z, last, box))
			boxes_due.push_back(typed ? typed_box : box);
	endtask

	// drain all boxes and let vertices without a box leave the pipeline
	task automatic settle();
		in_valid <= 1'b0;
		while (boxes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int w;
		wait (arst_n === 1'b1);
		forever begin
			w = draw_wait(take_calm);
			if (w != 0) begin
				out_ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		box_t want;
		if (arst_n && out_valid && out_ready) begin
			if (boxes_due.size() == 0) begin
				report($sformatf("box with no set pending: min %h %h %h max %h %h %h",
					min_x, min_y, min_z, max_x, max_y, max_z));
			end else begin
				want = boxes_due.pop_front();
				if (min_x !== want.min_x)
					report($sformatf("min_x got %h want %h", min_x, want.min_x));
				if (min_y !== want.min_y)
					report($sformatf("min_y got %h want %h", min_y, want.min_y));
				if (min_z !== want.min_z)
					report($sformatf("min_z got %h want %h", min_z, want.min_z));
				if (max_x !== want.max_x)
					report($sformatf("max_x got %h want %h", max_x, want.max_x));
				if (max_y !== want.max_y)
					report($sformatf("max_y got %h want %h", max_y, want.max_y));
				if (max_z !== want.max_z)
					report($sformatf("max_z got %h want %h", max_z, want.max_z));
			end
		end
	end

	initial begin
		row_t directed [NUM_ROWS];
		int   set_left;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		last_point = 1'b0;
		out_ready = 1'b0;
		coeff_regs = RESET_VALUES;
		run_lo = '{default: '0};
		run_hi = '{default: '0};
		run_open = 1'b0;
		error_count = 0;
		send_calm = 0;
		take_calm = 0;
		set_left = 0;

		directed = '{
			// identity transform after reset, single- and multi-vertex sets and extremes
			checked_row(32'h0, 32'h0, 32'h0, '0),
			checked_row(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
				box_t'{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
					32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF}),
			point_row(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b0),
			point_row(32'hFFFF_0000, 32'h0005_0000, 32'hFFF9_0000, 1'b0),
			checked_row(32'h0064_0000, 32'hFF9C_0000, 32'h0,
				box_t'{32'hFFFF_0000, 32'hFF9C_0000, 32'hFFF9_0000,
					32'h0064_0000, 32'h0005_0000, 32'h0003_0000}),
			point_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b0),
			checked_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
				box_t'{32'h8000_0000, 32'h8000_0000, 32'h0,
					32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}),
			// huge x gain, saturation both ways
			write_row(REG_ROW0_LO, 64'h0000_0000_7FFF_FFFF),
			checked_row(32'h7FFF_FFFF, 32'h5, 32'h6,
				box_t'{32'h7FFF_FFFF, 32'h5, 32'h6, 32'h7FFF_FFFF, 32'h5, 32'h6}),
			checked_row(32'h8000_0000, 32'hFFFF_FFFB, 32'h1,
				box_t'{32'h8000_0000, 32'hFFFF_FFFB, 32'h1,
					32'h8000_0000, 32'hFFFF_FFFB, 32'h1}),
			write_row(REG_ROW0_LO, ROW0_LO_RST),
			// translation on y, half gain on z with floor rounding of negatives
			write_row(REG_ROW1_HI, 64'h0001_0000_0002_0000),
			write_row(REG_ROW2_LO, 64'h0000_0000_0000_8000),
			checked_row(32'hFFFF_FFFD, 32'h0, 32'h0,
				box_t'{32'hFFFF_FFFD, 32'h0001_0000, 32'hFFFF_FFFE,
					32'hFFFF_FFFD, 32'h0001_0000, 32'hFFFF_FFFE}),
			point_row(32'h0003_8000, 32'hFFFF_8000, 32'h0012_3456, 1'b0),
			point_row(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0),
			point_row(32'h1234_5678, 32'hFEDC_BA98, 32'h0000_0001, 1'b1),
			// writes to unused indexes leave the transform alone
			write_row(REG_UNUSED_LO, '1),
			write_row(REG_UNUSED_HI, '1),
			point_row(32'h0001_0000, 32'hFFFE_0000, 32'h0003_0000, 1'b1)
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_WRITE) begin
				settle();
				write_reg(directed[i].index, directed[i].data);
				cfg_valid <= 1'b0;
			end else begin
				push_point(directed[i].x, directed[i].y, directed[i].z, directed[i].last,
					directed[i].typed, directed[i].box);
			end
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			settle();
			for (int r = 0; r < NUM_REGS; r++) begin
				if (PHASE_PLAN[ph] == SET_RESET)
					write_reg(REG_IDX_W'(r), RESET_VALUES[r]);
				else
					write_reg(REG_IDX_W'(r),
						{draw_half(PHASE_PLAN[ph]), draw_half(PHASE_PLAN[ph])});
			end
			if ($urandom_range(0, 2) == 0)
				write_reg($urandom_range(0, 1) ? REG_UNUSED_HI : REG_UNUSED_LO,
					{$urandom(), $urandom()});
			cfg_valid <= 1'b0;
			// sets may run on across a change of transform
			for (int k = 0; k < PHASE_POINTS; k++) begin
				if (set_left == 0)
					set_left = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24)
						: $urandom_range(1, 8);
				set_left--;
				push_point(draw_coord(), draw_coord(), draw_coord(), set_left == 0, 1'b0, '0);
			end
		end
		if (set_left != 0)
			push_point(draw_coord(), draw_coord(), draw_coord(), 1'b1, 1'b0, '0);
		settle();

		if (error_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/tbb_pkg.sv
hdl/tbb_front.sv
hdl/tbb_fifo.sv
hdl/tbb_back.sv
hdl/transformed_bounding_box.sv
test/testbench.sv
